### hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dacfb_pkg.sv
`timescale 1ns / 1ps
package dacfb_pkg;

  localparam int BlockBytes = 16;
  localparam int Rounds     = 10;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic         first_block;
    logic         decrypt;
    logic [127:0] iv;
    logic [127:0] data;
    logic [4:0]   byte_count;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } core_state_t;

  typedef enum logic [1:0] {
    REG_KEY1_HI = 2'd0,
    REG_KEY1_LO = 2'd1,
    REG_KEY2_HI = 2'd2,
    REG_KEY2_LO = 2'd3
  } reg_idx_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = '0;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    r = 8'h01;
    p = x;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gmul(r, p);
      p = gmul(p, p);
    end
    sbox = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
         ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  // byte i of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
    byte_at = v[127-8*i -: 8];
  endfunction

  // one AES round; last skips mix columns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] o  [16];
    logic [127:0] res;
    for (int i = 0; i < 16; i++) sb[i] = sbox(byte_at(s, i));
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = sb[r + 4*((c+r) & 3)];
    for (int c = 0; c < 4; c++) begin
      o[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      o[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      o[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      o[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = (last ? t[i] : o[i]);
    aes_round = res ^ k;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w [4];
    logic [31:0] g;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    g = {sbox(w[3][23:16]) ^ rcon, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ g;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    key_step = {w[0], w[1], w[2], w[3]};
  endfunction

endpackage

### hw/rtl/double_aes_cfb_cipher_top.sv
`timescale 1ns / 1ps
// two-key cfb cipher on aes-128
// keys k1, k2 are written over the apb port (64-bit data, 8-byte register spacing):
//   0x00 k1 bytes 0-7, 0x08 k1 bytes 8-15, 0x10 k2 bytes 0-7, 0x18 k2 bytes 8-15
// request channel: in_valid/in_stall with first_block, decrypt, iv, data, byte_count
// result channel: out_valid/out_stall with result_high/result_low
// result = data ^ E(k1,fb) ^ E(k2,fb), bytes beyond byte_count zero
// feedback then takes data ^ E(k1,fb), E(k2,fb) on decrypt, in its leading byte_count bytes
// a front queue of two requests takes requests while the back end works
// back end runs both aes cores one round per cycle in parallel
// a block is loaded into the cores in idle, runs the ten aes rounds in run and is
// written back in done; the cores take no new block until that write-back
// reset clears keys and feedback to zero and empties the queue
// a stalled result holds in its register; the cores wait for it before the
// next block, and the queue fills and then stalls the request side
module double_aes_cfb_cipher_top #(
  parameter int QueueDepth = dacfb_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_block,
  input  logic        decrypt,
  input  logic [63:0] iv_high,
  input  logic [63:0] iv_low,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  logic [63:0] k1h, k1l, k2h, k2l;
  logic [1:0]  ridx;
  logic        wr_en;
  dacfb_pkg::req_t in_req, q_req;
  logic        q_valid, q_pop;
  logic [127:0] result;

  assign pready = 1'b1;
  assign ridx   = paddr[4:3];
  // register index is paddr[4:3] only; low address bits are ignored and no other register exists
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1h <= '0;
      k1l <= '0;
      k2h <= '0;
      k2l <= '0;
    end else if (wr_en) begin
      unique case (dacfb_pkg::reg_idx_t'(ridx))
        dacfb_pkg::REG_KEY1_HI: k1h <= pwdata;
        dacfb_pkg::REG_KEY1_LO: k1l <= pwdata;
        dacfb_pkg::REG_KEY2_HI: k2h <= pwdata;
        dacfb_pkg::REG_KEY2_LO: k2l <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (dacfb_pkg::reg_idx_t'(ridx))
      dacfb_pkg::REG_KEY1_HI: prdata = k1h;
      dacfb_pkg::REG_KEY1_LO: prdata = k1l;
      dacfb_pkg::REG_KEY2_HI: prdata = k2h;
      dacfb_pkg::REG_KEY2_LO: prdata = k2l;
      default: prdata = '0;
    endcase
  end

  assign in_req.first_block = first_block;
  assign in_req.decrypt     = decrypt;
  assign in_req.iv          = {iv_high, iv_low};
  assign in_req.data        = {data_high, data_low};
  assign in_req.byte_count  = byte_count;

  dacfb_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  dacfb_back u_back (
    .clk(clk), .rst(rst),
    .key1({k1h, k1l}), .key2({k2h, k2l}),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .out_valid(out_valid), .out_stall(out_stall), .result(result)
  );

  assign result_high = result[127:64];
  assign result_low  = result[63:0];

endmodule

### hw/rtl/dacfb_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// input stage and request queue
module dacfb_front #(
  parameter int Depth = dacfb_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dacfb_pkg::req_t   in_req,
  output logic              q_valid,
  input  logic              q_pop,
  output dacfb_pkg::req_t   q_req
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  dacfb_pkg::req_t  mem [Depth];
  dacfb_pkg::req_t  in_sat;
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_stall = (count == (AW+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_req    = mem[rd_ptr];

  always_comb begin
    in_sat = in_req;
    // saturate the count so the back end only sees 0..16
    if (in_req.byte_count > 5'(dacfb_pkg::BlockBytes))
      in_sat.byte_count = 5'(dacfb_pkg::BlockBytes);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `CHK_IMPLY(a_no_overflow, clk, rst, count == (AW+1)'(Depth), !push, "queue overflow")
  `CHK_IMPLY(a_count_range, clk, rst, 1'b1, count <= (AW+1)'(Depth), "queue count out of range")
  `CHK_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

### hw/rtl/dacfb_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// two AES-128 cores, one round per cycle each, plus feedback and output register
module dacfb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [127:0]      key1,
  input  logic [127:0]      key2,
  input  logic              q_valid,
  output logic              q_pop,
  input  dacfb_pkg::req_t   q_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [127:0]      result
);

  dacfb_pkg::core_state_t state;
  logic [3:0]   round;
  logic [127:0] s1, s2, rk1, rk2;
  logic [7:0]   rcon;
  logic [127:0] fb;
  dacfb_pkg::req_t cur;
  logic [127:0] fb_start;
  logic         start;
  logic         last;
  logic         emit;
  logic [127:0] mask;
  logic [127:0] ef;
  logic [127:0] nk1, nk2;

  assign fb_start = q_req.first_block ? q_req.iv : fb;
  // feedback is written back in done, before the next block starts
  assign start = (state == dacfb_pkg::ST_IDLE) && q_valid;
  assign q_pop = start;
  assign last  = (round == 4'(dacfb_pkg::Rounds));
  // result register free or being taken this cycle
  assign emit  = (state == dacfb_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign nk1   = dacfb_pkg::key_step(rk1, rcon);
  assign nk2   = dacfb_pkg::key_step(rk2, rcon);

  always_comb begin
    for (int i = 0; i < dacfb_pkg::BlockBytes; i++)
      mask[127-8*i -: 8] = (5'(i) < cur.byte_count) ? 8'hff : 8'h00;
    ef = cur.decrypt ? s2 : s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dacfb_pkg::ST_IDLE;
      out_valid <= 1'b0;
      fb        <= '0;
      round     <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        dacfb_pkg::ST_IDLE: begin
          if (start) begin
            cur   <= q_req;
            fb    <= fb_start;
            s1    <= fb_start ^ key1;
            s2    <= fb_start ^ key2;
            rk1   <= key1;
            rk2   <= key2;
            rcon  <= 8'h01;
            round <= 4'd1;
            state <= dacfb_pkg::ST_RUN;
          end
        end
        dacfb_pkg::ST_RUN: begin
          s1    <= dacfb_pkg::aes_round(s1, nk1, last);
          s2    <= dacfb_pkg::aes_round(s2, nk2, last);
          rk1   <= nk1;
          rk2   <= nk2;
          rcon  <= dacfb_pkg::xtime(rcon);
          round <= round + 4'd1;
          if (last) state <= dacfb_pkg::ST_DONE;
        end
        dacfb_pkg::ST_DONE: begin
          if (emit) begin
            fb    <= ((cur.data ^ ef) & mask) | (fb & ~mask);
            state <= dacfb_pkg::ST_IDLE;
          end
        end
        default: state <= dacfb_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= (cur.data ^ s1 ^ s2) & mask;
    end
  end

  `CHK_IMPLY(a_pop_idle, clk, rst, q_pop, state == dacfb_pkg::ST_IDLE, "pop outside idle")
  `CHK_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(result),
            "stalled result changed")
  `CHK_IMPLY(a_round_range, clk, rst, state == dacfb_pkg::ST_RUN,
             round >= 4'd1 && round <= 4'(dacfb_pkg::Rounds), "round out of range")

endmodule

### verif/double_aes_cfb_cipher_top_test.sv
`timescale 1ns / 1ps
module double_aes_cfb_cipher_top_test;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first_block = 1'b0;
  logic        decrypt = 1'b0;
  logic [63:0] iv_high = '0;
  logic [63:0] iv_low = '0;
  logic [63:0] data_high = '0;
  logic [63:0] data_low = '0;
  logic [4:0]  byte_count = 5'd16;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;

  double_aes_cfb_cipher_top dut (.*);

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: keys and the feedback register
  logic [127:0] key_one, key_two, feedback;
  logic [127:0] result_queue [$];
  int unsigned  fail_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  quiet_cycles = 0;

  // aes-128 block encryption, written out byte by byte
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] inv, pw;
    logic [7:0] expo;
    inv = 8'h01;
    pw = x;
    expo = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (expo[i]) inv = gf_mult(inv, pw);
      pw = gf_mult(pw, pw);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                              input logic [127:0] blk);
    logic [7:0] kb [16];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] w0, w1, w2, w3, rc, a0, a1, a2, a3;
    logic [127:0] outv;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      kb[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8] ^ kb[i];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) st[i] = sub_byte(st[i]);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) sh[r+4*c] = st[r + 4*((c+r) & 3)];
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
        if (rnd < 10) begin
          st[4*c]   = gf_mult(a0, 8'd2) ^ gf_mult(a1, 8'd3) ^ a2 ^ a3;
          st[4*c+1] = a0 ^ gf_mult(a1, 8'd2) ^ gf_mult(a2, 8'd3) ^ a3;
          st[4*c+2] = a0 ^ a1 ^ gf_mult(a2, 8'd2) ^ gf_mult(a3, 8'd3);
          st[4*c+3] = gf_mult(a0, 8'd3) ^ a1 ^ a2 ^ gf_mult(a3, 8'd2);
        end else begin
          st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
        end
      end
      // next round key
      w0 = sub_byte(kb[13]); w1 = sub_byte(kb[14]);
      w2 = sub_byte(kb[15]); w3 = sub_byte(kb[12]);
      kb[0] ^= w0 ^ rc; kb[1] ^= w1; kb[2] ^= w2; kb[3] ^= w3;
      for (int i = 4; i < 16; i++) kb[i] ^= kb[i-4];
      rc = gf_double(rc);
      for (int i = 0; i < 16; i++) st[i] ^= kb[i];
    end
    for (int i = 0; i < 16; i++) outv[127-8*i -: 8] = st[i];
    return outv;
  endfunction

  // advance the cipher state for one accepted request and queue its result
  task automatic predict_block(input logic first, input logic dec, input logic [127:0] iv,
                               input logic [127:0] data, input logic [4:0] count);
    logic [127:0] ks_one, ks_two, ks_fb, res;
    int n;
    n = (count > 16) ? 16 : count;
    if (first) feedback = iv;
    ks_one = aes_encrypt(key_one, feedback);
    ks_two = aes_encrypt(key_two, feedback);
    ks_fb = dec ? ks_two : ks_one;
    res = '0;
    for (int i = 0; i < n; i++) begin
      res[127-8*i -: 8] = data[127-8*i -: 8] ^ ks_one[127-8*i -: 8] ^ ks_two[127-8*i -: 8];
      feedback[127-8*i -: 8] = data[127-8*i -: 8] ^ ks_fb[127-8*i -: 8];
    end
    result_queue.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // result checker, sampled at the rising edge (the receiver stall is driven at the falling edge)
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result high", result_high, '0);
        end else begin
          want = result_queue.pop_front();
          if (result_high !== want[127:64]) report_mismatch("result_high", result_high,
                                                            want[127:64]);
          if (result_low !== want[63:0]) report_mismatch("result_low", result_low,
                                                         want[63:0]);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with neither a request accepted nor a result taken
  always @(posedge clk) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // apb write with setup and access phases, then update the predictor keys
  task automatic write_key(input dacfb_pkg::reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(int'(idx) * 8); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      dacfb_pkg::REG_KEY1_HI: key_one[127:64] = value;
      dacfb_pkg::REG_KEY1_LO: key_one[63:0] = value;
      dacfb_pkg::REG_KEY2_HI: key_two[127:64] = value;
      dacfb_pkg::REG_KEY2_LO: key_two[63:0] = value;
    endcase
  endtask

  task automatic set_keys(input logic [127:0] k1, input logic [127:0] k2);
    write_key(dacfb_pkg::REG_KEY1_HI, k1[127:64]);
    write_key(dacfb_pkg::REG_KEY1_LO, k1[63:0]);
    write_key(dacfb_pkg::REG_KEY2_HI, k2[127:64]);
    write_key(dacfb_pkg::REG_KEY2_LO, k2[63:0]);
  endtask

  // send one request; held until accepted, valid stays up for a following request
  task automatic send_block(input logic first, input logic dec, input logic [127:0] iv,
                            input logic [127:0] data, input logic [4:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    first_block <= first; decrypt <= dec;
    iv_high <= iv[127:64]; iv_low <= iv[63:0];
    data_high <= data[127:64]; data_low <= data[63:0];
    byte_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_block(first, dec, iv, data, count);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // directed: field extremes, both directions, zero and oversized counts,
  // no first block after reset, iv ignored on later blocks
  task automatic test_directed();
    send_block(1'b0, 1'b0, '1, '0, 5'd16);
    send_block(1'b0, 1'b1, '1, '1, 5'd16);
    send_block(1'b1, 1'b0, '0, '0, 5'd16);
    send_block(1'b1, 1'b1, '1, '1, 5'd1);
    send_block(1'b0, 1'b0, rand128(), rand128(), 5'd0);
    send_block(1'b0, 1'b1, rand128(), rand128(), 5'd31);
    send_block(1'b0, 1'b0, rand128(), rand128(), 5'd17);
    send_block(1'b1, 1'b0, rand128(), rand128(), 5'd15);
    send_block(1'b0, 1'b1, '1, rand128(), 5'd8);
    send_block(1'b0, 1'b0, '0, rand128(), 5'd7);
    wait_drained();
    set_keys('1, '1);
    send_block(1'b1, 1'b0, rand128(), '1, 5'd16);
    send_block(1'b0, 1'b1, rand128(), '0, 5'd9);
    wait_drained();
    set_keys('0, '1);
    send_block(1'b1, 1'b1, '0, rand128(), 5'd16);
    send_block(1'b0, 1'b0, '0, rand128(), 5'd16);
    wait_drained();
  endtask

  // random messages: mostly well-formed chains, with odd counts mixed in
  task automatic test_random_messages(input int n_items);
    int sent;
    int len;
    logic dec;
    logic [127:0] iv;
    logic [4:0] cnt;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(8, 1);
      dec = 1'($urandom_range(1));
      iv = rand128();
      for (int b = 0; b < len && sent < n_items; b++) begin
        if ($urandom_range(9) == 0) cnt = 5'($urandom);
        else if (b == len - 1) cnt = 5'($urandom_range(16, 1));
        else cnt = 5'd16;
        send_block(b == 0 ? 1'b1 : ($urandom_range(19) == 0),
                   ($urandom_range(9) == 0) ? ~dec : dec,
                   (b == 0) ? iv : rand128(), rand128(), cnt);
        sent++;
      end
    end
  endtask

  // sender holds off until every queued result is back
  task automatic test_pause_until_empty();
    send_block(1'b1, 1'b0, rand128(), rand128(), 5'd16);
    send_block(1'b0, 1'b0, rand128(), rand128(), 5'd16);
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    @(negedge clk);
    send_block(1'b0, 1'b1, rand128(), rand128(), 5'd12);
  endtask

  initial begin
    key_one = '0;
    key_two = '0;
    feedback = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_stall_pct = 48;
    test_directed();
    set_keys(rand128(), rand128());
    test_random_messages(430);
    test_pause_until_empty();
    wait_drained();
    send_idle_pct = 48;
    recv_stall_pct = 27;
    set_keys(rand128(), rand128());
    test_random_messages(430);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_keys(rand128(), rand128());
    test_random_messages(430);
    wait_drained();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dacfb_pkg.sv
hw/rtl/dacfb_front.sv
hw/rtl/dacfb_back.sv
hw/rtl/double_aes_cfb_cipher_top.sv
verif/double_aes_cfb_cipher_top_test.sv
